### sv/assert_macros.svh
// Assertion macros used by the back end of the back projection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define SBP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/sbp_pkg.sv
// Shared constants, types and codes of the back projection block.
`default_nettype none
package sbp_pkg;
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int NR_W   = $clog2(MAX_ROWS + 1);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DW     = (COL_W > 8) ? COL_W : 8;
  localparam int SQ_W   = 2 * DW + 1;
  localparam int STEPS  = DW + 1;
  localparam int ACC_W  = $clog2(MAX_COLS) + 17;

  localparam int CFG_W  = 9;
  localparam int IDX_W  = 2;
  localparam int SAMP_W = 16;
  localparam int PIX_W  = 24;
  localparam int PIX_MAX = 8388607;
  localparam int PIX_MIN = -8388608;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic [IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [IDX_W-1:0] REG_NUM_COLS = 2'd1;
  localparam logic [CFG_W-1:0] CFG_RESET    = 9'd256;

  typedef enum logic {OP_WRITE, OP_PIXEL} op_t;

  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   waddr;
    logic [7:0]          col;
    logic [7:0]          row;
    logic [2*SAMP_W-1:0] data;
  } item_t;

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_DIV, B_OUT} back_state_t;
endpackage
`default_nettype wire

### sv/sbp_if.sv
// Valid/ready channel interfaces for requests and pixels.
`default_nettype none
interface sbp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  col;
  logic [7:0]  row;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;
  modport source (output valid, func, col, row, sample_re, sample_im, input ready);
  modport sink   (input valid, func, col, row, sample_re, sample_im, output ready);
endinterface

interface sbp_out_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] pixel_re;
  logic signed [23:0] pixel_im;
  modport source (output valid, pixel_re, pixel_im, input ready);
  modport sink   (input valid, pixel_re, pixel_im, output ready);
endinterface
`default_nettype wire

### sv/sar_back_projection_pixel.sv
// Top level of the back projection pixel block.
// A sample write is done in the back end after passing the two-entry
// queue. A pixel request sweeps the columns (one column per cycle through
// the square-root pipeline and the single read port of the sample store),
// then runs through the bit-serial divider to the output register. The
// store has no reset and no clearing pass; only written entries may be
// read by a pixel.
`default_nettype none
module sar_back_projection_pixel
  import sbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  sbp_in_if.sink           in_ch,
  sbp_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  logic [CFG_W-1:0] num_rows_r, num_cols_r;
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_in, q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= CFG_RESET;
      num_cols_r <= CFG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_ROWS) num_rows_r <= cfg_data;
      if (cfg_index == REG_NUM_COLS) num_cols_r <= cfg_data;
    end
  end

  sbp_front u_front (
    .in_ch(in_ch), .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  sbp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .item_in(q_in), .full(q_full),
    .pop(q_pop), .item_out(q_out), .empty(q_empty)
  );

  sbp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_item(q_out), .q_pop(q_pop),
    .num_rows(num_rows_r), .num_cols(num_cols_r), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

### sv/sbp_front.sv
// Front end: accept requests, classify them and push them into the queue.
`default_nettype none
module sbp_front
  import sbp_pkg::*;
(
  sbp_in_if.sink  in_ch,
  input  logic    q_full,
  output logic    q_push,
  output item_t   q_item
);
  logic in_store;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;

  // drop writes that fall outside the store
  assign in_store = (int'(in_ch.col) < MAX_COLS) && (int'(in_ch.row) < MAX_ROWS);
  assign q_push   = in_ch.valid && !q_full && (in_ch.func || in_store);

  always_comb begin
    q_item.op    = in_ch.func ? OP_PIXEL : OP_WRITE;
    q_item.waddr = ADDR_W'(ADDR_W'(in_ch.col) * ADDR_W'(MAX_ROWS) + ADDR_W'(in_ch.row));
    q_item.col   = in_ch.col;
    q_item.row   = in_ch.row;
    q_item.data  = {in_ch.sample_re, in_ch.sample_im};
  end
endmodule
`default_nettype wire

### sv/sbp_fifo.sv
// Two-entry queue between front end and back end.
`default_nettype none
module sbp_fifo
  import sbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t item_in,
  output logic  full,
  input  logic  pop,
  output item_t item_out,
  output logic  empty
);
  item_t             ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full     = (int'(cnt_r) == QDEPTH);
  assign empty    = (cnt_r == '0);
  assign item_out = ent_r[rd_ptr_r];

  // store entries
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= item_in;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule
`default_nettype wire

### sv/sbp_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module sbp_div
  import sbp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] dividend,
  input  logic [NR_W-1:0]         divisor,
  output logic                    done,
  output logic signed [PIX_W-1:0] quo
);
  localparam int CNTD_W = $clog2(ACC_W + 1);
  localparam int SW     = ACC_W + 1;

  logic                    busy_r, done_r, neg_r;
  logic [CNTD_W-1:0]       cnt_r;
  logic [NR_W:0]           rem_r;
  logic [ACC_W-1:0]        sh_r;
  logic signed [PIX_W-1:0] quo_r;
  logic [NR_W+1:0]         trial;
  logic                    ge;
  logic signed [SW-1:0]    qs;

  assign trial = {rem_r, sh_r[ACC_W-1]};
  assign ge    = (trial >= (NR_W+2)'(divisor));
  assign qs    = neg_r ? -$signed({1'b0, sh_r}) : $signed({1'b0, sh_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTD_W'(ACC_W);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out and the quotient in; saturate at the end
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[ACC_W-1];
      sh_r  <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      rem_r <= '0;
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= ge ? (NR_W+1)'(trial - (NR_W+2)'(divisor)) : (NR_W+1)'(trial);
      sh_r  <= {sh_r[ACC_W-2:0], ge};
    end else if (busy_r) begin
      if (qs > SW'(PIX_MAX))      quo_r <= PIX_W'(PIX_MAX);
      else if (qs < SW'(PIX_MIN)) quo_r <= PIX_W'(PIX_MIN);
      else                        quo_r <= PIX_W'(qs);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

### sv/sbp_back.sv
// Back end: sample store, range pipeline, accumulation and pixel output.
`default_nettype none
`include "assert_macros.svh"
module sbp_back
  import sbp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  item_t           q_item,
  output logic            q_pop,
  input  logic [CFG_W-1:0] num_rows,
  input  logic [CFG_W-1:0] num_cols,
  sbp_out_if.source       out_ch
);
  back_state_t state_r, state_nxt;

  logic [NR_W-1:0]  nr_eff, nr_r;
  logic [CNT_W-1:0] nc_eff, nc_r, l_r;
  logic [7:0]       col_r, row_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;

  logic             sq_v_r   [STEPS+1];
  logic [COL_W-1:0] sq_l_r   [STEPS+1];
  logic [SQ_W-1:0]  sq_x_r   [STEPS+1];
  logic [SQ_W-1:0]  sq_res_r [STEPS+1];
  logic             sq_v_nxt   [STEPS+1];
  logic [COL_W-1:0] sq_l_nxt   [STEPS+1];
  logic [SQ_W-1:0]  sq_x_nxt   [STEPS+1];
  logic [SQ_W-1:0]  sq_res_nxt [STEPS+1];

  logic [2*SAMP_W-1:0] mem [DEPTH];
  logic [2*SAMP_W-1:0] rd_data_r;
  logic                rd_v_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic [STEPS-1:0]    rng;
  logic                hit, issue, pipe_busy, start_px, wr_en;
  logic                div_start, div_done, out_load, out_valid_r;
  logic [DW-1:0]       lx, cx, rx, dd;
  logic signed [PIX_W-1:0] q_re, q_im;
  logic signed [PIX_W-1:0] pix_re_r, pix_im_r;

  // clamp registers to their legal range
  always_comb begin
    if (num_rows == '0)                nr_eff = NR_W'(1);
    else if (int'(num_rows) > MAX_ROWS) nr_eff = NR_W'(MAX_ROWS);
    else                                nr_eff = NR_W'(num_rows);
    if (num_cols == '0)                nc_eff = CNT_W'(1);
    else if (int'(num_cols) > MAX_COLS) nc_eff = CNT_W'(MAX_COLS);
    else                                nc_eff = CNT_W'(num_cols);
  end

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign wr_en    = q_pop && (q_item.op == OP_WRITE);
  assign start_px = q_pop && (q_item.op == OP_PIXEL);
  assign issue    = (state_r == B_RUN) && (l_r < nc_r);

  always_comb begin
    pipe_busy = rd_v_r;
    for (int k = 0; k <= STEPS; k++) pipe_busy = pipe_busy | sq_v_r[k];
  end

  assign div_start = (state_r == B_RUN) && (l_r == nc_r) && !pipe_busy;
  assign out_load  = (state_r == B_OUT) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (start_px) state_nxt = B_RUN;
      B_RUN:   if (div_start) state_nxt = B_DIV;
      B_DIV:   if (div_done) state_nxt = B_OUT;
      B_OUT:   if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  // latch the pixel request and step the column counter
  always_ff @(posedge clk) begin
    if (start_px) begin
      col_r <= q_item.col;
      row_r <= q_item.row;
      nr_r  <= nr_eff;
      nc_r  <= nc_eff;
      l_r   <= '0;
    end else if (issue) begin
      l_r <= l_r + 1'b1;
    end
  end

  // distance squared for this column, then one root bit per stage
  assign lx = DW'(l_r[COL_W-1:0]);
  assign cx = DW'(col_r);
  assign rx = DW'(row_r);
  assign dd = (lx >= cx) ? (lx - cx) : (cx - lx);

  always_comb begin
    logic [SQ_W:0] b, t;
    sq_v_nxt[0]   = issue;
    sq_l_nxt[0]   = l_r[COL_W-1:0];
    sq_x_nxt[0]   = SQ_W'(SQ_W'(dd) * SQ_W'(dd) + SQ_W'(rx) * SQ_W'(rx));
    sq_res_nxt[0] = '0;
    for (int k = 0; k < STEPS; k++) begin
      b = (SQ_W+1)'(1) << (2 * (STEPS - 1 - k));
      t = (SQ_W+1)'(sq_res_r[k]) + b;
      sq_v_nxt[k+1] = sq_v_r[k];
      sq_l_nxt[k+1] = sq_l_r[k];
      if ((SQ_W+1)'(sq_x_r[k]) >= t) begin
        sq_x_nxt[k+1]   = SQ_W'((SQ_W+1)'(sq_x_r[k]) - t);
        sq_res_nxt[k+1] = SQ_W'((sq_res_r[k] >> 1) + SQ_W'(b));
      end else begin
        sq_x_nxt[k+1]   = sq_x_r[k];
        sq_res_nxt[k+1] = sq_res_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= STEPS; k++) sq_v_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k <= STEPS; k++) sq_v_r[k] <= sq_v_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= STEPS; k++) begin
      sq_l_r[k]   <= sq_l_nxt[k];
      sq_x_r[k]   <= sq_x_nxt[k];
      sq_res_r[k] <= sq_res_nxt[k];
    end
  end

  // drop ranges beyond the image, read the store
  assign rng     = sq_res_r[STEPS][STEPS-1:0];
  assign hit     = sq_v_r[STEPS] && (int'(rng) < int'(nr_r));
  assign rd_addr = ADDR_W'(ADDR_W'(sq_l_r[STEPS]) * ADDR_W'(MAX_ROWS) + ADDR_W'(rng));

  always_ff @(posedge clk) begin
    if (wr_en) mem[q_item.waddr] <= q_item.data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_v_r <= 1'b0;
    else        rd_v_r <= hit;
  end

  // accumulate both parts
  always_ff @(posedge clk) begin
    if (start_px) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (rd_v_r) begin
      acc_re_r <= acc_re_r + ACC_W'($signed(rd_data_r[2*SAMP_W-1:SAMP_W]));
      acc_im_r <= acc_im_r + ACC_W'($signed(rd_data_r[SAMP_W-1:0]));
    end
  end

  sbp_div u_div_re (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_re_r),
    .divisor(nr_r), .done(div_done), .quo(q_re)
  );

  sbp_div u_div_im (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_im_r),
    .divisor(nr_r), .done(), .quo(q_im)
  );

  // output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pix_re_r <= q_re;
      pix_im_r <= q_im;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.pixel_re = pix_re_r;
  assign out_ch.pixel_im = pix_im_r;

  `SBP_ASSERT(a_idle_drained, (state_r == B_IDLE) |-> !pipe_busy, "pipeline busy while idle")
  `SBP_ASSERT(a_done_in_div, div_done |-> (state_r == B_DIV), "divider done outside divide")
  `SBP_ASSERT(a_issue_bound, (state_r == B_RUN) |-> (l_r <= nc_r), "column counter overran")
  `SBP_NEVER(a_pop_busy, q_pop && (state_r != B_IDLE), "queue popped while busy")
endmodule
`default_nettype wire
